@@ hdl/chpl_pkg.sv @@
// package for the chained hash palette lookup unit
// holds sizes, codes, state type and the hashing and key compare functions
// no dependencies
package chpl_pkg;

  // table sizes
  localparam int BUCKETS       = 256;
  localparam int ENTRIES       = 256;
  localparam int MAX_KEY_BYTES = 3;

  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int ENTRY_W  = $clog2(ENTRIES);
  localparam int NEXT_W   = ENTRY_W + 1;
  localparam int USED_W   = ENTRY_W + 1;

  // field widths
  localparam int FUNC_W    = 2;
  localparam int KEY_BYTES = 3;
  localparam int KEY_W     = 8 * KEY_BYTES;
  localparam int COLOR_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int LEN_W     = 2;

  localparam int HASH_MULT = 33;

  // one entry word: key, colour, next link from the lowest bit up
  localparam int ENT_W = KEY_W + COLOR_W + NEXT_W;

  // stream widths, padded to whole bytes
  localparam int S_FIELDS_W = FUNC_W + KEY_W + COLOR_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = COLOR_W + STATUS_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_LOOKUP = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_RESP
  } state_e;

  // one stored entry
  typedef struct packed {
    logic [NEXT_W-1:0]  next;
    logic [COLOR_W-1:0] color;
    logic [KEY_W-1:0]   key;
  } entry_t;

  // effective key length: zero reads as one, saturated to the maximum
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] n;
    n = raw;
    if (n == '0) n = LEN_W'(1);
    if (int'(n) > MAX_KEY_BYTES) n = LEN_W'(MAX_KEY_BYTES);
    return n;
  endfunction

  // times-33 hash over the first len bytes, kept to the bucket index width
  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [KEY_W-1:0] key,
                                                    input logic [LEN_W-1:0] len);
    logic [BUCKET_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i < int'(len)) begin
        h = BUCKET_W'(h * BUCKET_W'(HASH_MULT)) + BUCKET_W'(key[8*i +: 8]);
      end
    end
    return h;
  endfunction

  // compare the first len bytes of two keys
  function automatic logic keys_match(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b,
                                      input logic [LEN_W-1:0] len);
    logic m;
    m = 1'b1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (i < int'(len) && a[8*i +: 8] != b[8*i +: 8]) m = 1'b0;
    end
    return m;
  endfunction

endpackage

@@ hdl/chained_hash_palette_lookup_unit.sv @@
// flow: an accepted request passes the head stage and the response stage into the result register;
// a lookup walks the chain entries between them, one entry ram read each
// throughput: one request in flight; a new request is taken only in the idle state
// reset: bucket valid bits and the fill count clear at once, key length returns to 1;
// the head and entry rams are not cleared and need no clearing pass
// depends on chpl_pkg and chpl_ram
module chained_hash_palette_lookup_unit
  import chpl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: key length
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LEN_W-1:0]     cfg_data_i,
  // request stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // func, key, color_in, zero pad
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // color_out, status, zero pad
);

  state_e               state_q, state_d;
  func_e                func_q, func_d;
  logic [KEY_W-1:0]     key_q, key_d;
  logic [COLOR_W-1:0]   color_q, color_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [BUCKET_W-1:0]  bkt_q, bkt_d;
  logic [USED_W-1:0]    used_q, used_d;
  logic [BUCKETS-1:0]   valid_q, valid_d;
  logic [LEN_W-1:0]     key_len_q, key_len_d;
  logic [COLOR_W-1:0]   res_color_q, res_color_d;
  status_e              res_status_q, res_status_d;
  logic                 out_valid_q, out_valid_d;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;

  // ram ports
  logic                 head_we, head_re;
  logic [BUCKET_W-1:0]  head_waddr, head_raddr;
  logic [ENTRY_W-1:0]   head_wdata, head_rdata;
  logic                 ent_we, ent_re;
  logic [ENTRY_W-1:0]   ent_waddr, ent_raddr;
  entry_t               ent_wdata, ent_rdata;
  logic [ENT_W-1:0]     ent_rdata_raw;

  // request fields and their bucket
  func_e                in_func;
  logic [KEY_W-1:0]     in_key;
  logic [COLOR_W-1:0]   in_color;
  logic [LEN_W-1:0]     in_len;
  logic [BUCKET_W-1:0]  in_bkt;
  logic                 full;

  assign in_func  = func_e'(s_axis_tdata[FUNC_W-1:0]);
  assign in_key   = s_axis_tdata[FUNC_W +: KEY_W];
  assign in_color = s_axis_tdata[FUNC_W+KEY_W +: COLOR_W];
  assign in_len   = eff_len(key_len_q);
  assign in_bkt   = bucket_of(in_key, in_len);
  assign full     = (used_q >= USED_W'(ENTRIES));
  assign ent_rdata = entry_t'(ent_rdata_raw);

  // bucket head store
  chpl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (BUCKETS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  // entry store: key, colour and older link
  chpl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata_raw)
  );

  // configuration register is always ready
  assign cfg_ready_o = 1'b1;
  always_comb begin
    key_len_d = key_len_q;
    if (cfg_valid_i) key_len_d = cfg_data_i;
  end

  // next state and datapath control
  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    key_d        = key_q;
    color_d      = color_q;
    len_d        = len_q;
    bkt_d        = bkt_q;
    used_d       = used_q;
    valid_d      = valid_q;
    res_color_d  = res_color_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    s_axis_tready = 1'b0;
    head_we      = 1'b0;
    head_re      = 1'b0;
    head_waddr   = bkt_q;
    head_wdata   = used_q[ENTRY_W-1:0];
    head_raddr   = in_bkt;
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    ent_waddr    = used_q[ENTRY_W-1:0];
    ent_wdata.key   = key_q;
    ent_wdata.color = color_q;
    ent_wdata.next  = valid_q[bkt_q] ? NEXT_W'({1'b0, head_rdata} + NEXT_W'(1)) : '0;
    ent_raddr    = head_rdata;

    // output register drains on a taken result
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          func_d  = in_func;
          key_d   = in_key;
          color_d = in_color;
          len_d   = in_len;
          bkt_d   = in_bkt;
          head_re = 1'b1;
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        res_color_d  = '0;
        res_status_d = STAT_DONE;
        state_d      = ST_RESP;
        case (func_q)
          FUNC_CLEAR: begin
            valid_d = '0;
            used_d  = '0;
          end
          FUNC_INSERT: begin
            if (full) begin
              res_status_d = STAT_FULL;
            end else begin
              ent_we         = 1'b1;
              head_we        = 1'b1;
              valid_d[bkt_q] = 1'b1;
              used_d         = used_q + USED_W'(1);
            end
          end
          FUNC_LOOKUP: begin
            if (valid_q[bkt_q]) begin
              ent_re  = 1'b1;
              state_d = ST_WALK;
            end else begin
              res_status_d = STAT_MISS;
            end
          end
          default: begin
          end
        endcase
      end
      ST_WALK: begin
        // one chain entry per cycle
        if (keys_match(key_q, ent_rdata.key, len_q)) begin
          res_color_d  = ent_rdata.color;
          res_status_d = STAT_DONE;
          state_d      = ST_RESP;
        end else if (ent_rdata.next == '0) begin
          res_color_d  = '0;
          res_status_d = STAT_MISS;
          state_d      = ST_RESP;
        end else begin
          ent_re    = 1'b1;
          ent_raddr = ENTRY_W'(ent_rdata.next - NEXT_W'(1));
        end
      end
      ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = M_TDATA_W'({res_status_q, res_color_q});
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      valid_q     <= '0;
      key_len_q   <= LEN_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      valid_q     <= valid_d;
      key_len_q   <= key_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    key_q        <= key_d;
    color_q      <= color_d;
    len_q        <= len_d;
    bkt_q        <= bkt_d;
    res_color_q  <= res_color_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // fill count never passes the store size
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= USED_W'(ENTRIES))
    else $error("fill count beyond store size");

  // an accepted request always starts with the head read
  a_accept_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> state_q == ST_HEAD)
    else $error("accepted request did not reach head stage");

  // an insert with room adds exactly one entry
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HEAD && func_q == FUNC_INSERT && !full)
      |=> used_q == $past(used_q) + USED_W'(1))
    else $error("insert did not advance fill count");

  // a new result only comes from the response stage
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result appeared outside the response stage");
`endif

endmodule

@@ hdl/chpl_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module chpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
